>>> rtl/core/html_char_reference_decoder_top_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the character reference decoder
// Clocked on clk_i and held off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef HTML_CHAR_REFERENCE_DECODER_TOP_MACROS_SVH
`define HTML_CHAR_REFERENCE_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hcr_pkg.sv
// -----------------------------------------------------------------------------
// Character reference decoder package
// Shared types, sizes, name tables and the digit decode function.
// -----------------------------------------------------------------------------
package hcr_pkg;

  localparam int unsigned BufferBytes = 32;
  localparam int unsigned AddrW       = $clog2(BufferBytes);
  localparam int unsigned EchoLimit   = (BufferBytes < 32) ? BufferBytes : 32;
  localparam int unsigned CountW      = 7;
  localparam int unsigned NumNames    = 6;

  localparam logic [CountW-1:0] CountMax     = 7'd127;
  localparam logic [CountW-1:0] BufferBytesC = CountW'(BufferBytes);
  localparam logic [CountW-1:0] EchoLimitC   = CountW'(EchoLimit);

  localparam logic [20:0] CodeMax      = 21'h10FFFF;
  localparam logic [20:0] UnitMax      = 21'h00FFFF;
  localparam logic [20:0] SurrOffset   = 21'h010000;
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;

  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharUpperX = 8'h58;

  // Named references, padded to eight bytes: amp, lt, gt, quot, apos, nbsp.
  localparam logic [7:0] NameText [NumNames][8] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00}
  };
  localparam logic [2:0]  NameLen  [NumNames] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
  localparam logic [15:0] NameUnit [NumNames] = '{
    16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h00A0
  };

  typedef struct packed {
    logic [7:0] entity_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [15:0] unit_value;
    logic        is_raw_byte;
    logic        run_end;
    logic        truncated;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_SINGLE,
    SEL_HIGH,
    SEL_LOW,
    SEL_RAW
  } out_sel_e;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_PAIR,
    KIND_ECHO
  } ref_kind_e;

  typedef struct packed {
    logic     take;
    logic     clear;
    logic     rd_start;
    logic     rd_next;
    logic     load;
    out_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    ref_kind_e kind;
    logic      echo_last;
  } dp_status_t;

  // Bit 4 flags a valid digit of the current base, bits 3:0 hold its value.
  function automatic logic [4:0] digit_value(input logic [7:0] b, input logic hex);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (hex && ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/html_char_reference_decoder_top.sv
// -----------------------------------------------------------------------------
// Character reference decoder: one byte per cycle until the final byte.
// After the final byte's transfer the input stalls while the controller
// passes through a decision state, which also starts the registered read of
// the byte buffer, then loads the results into the output register, one per
// cycle when the output is not stalled; input is taken again after the last.
// Reset clears all control state; the buffer is not cleared.
// -----------------------------------------------------------------------------
module html_char_reference_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hcr_pkg::out_item_t out_data_o
);
  import hcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_final_i  (in_data_i.is_final),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  hcr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/core/hcr_datapath.sv
// -----------------------------------------------------------------------------
// Character reference decoder datapath
// Byte buffer, digit accumulator, name matching, result formatting and the
// output register.
// -----------------------------------------------------------------------------
module hcr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcr_pkg::in_item_t  in_data_i,
  input  hcr_pkg::dp_cmd_t   cmd_i,
  output hcr_pkg::dp_status_t status_o,
  output hcr_pkg::out_item_t out_data_o
);
  import hcr_pkg::*;

  logic [CountW-1:0]   count_q, count_d;
  logic [20:0]         code_q, code_d;
  logic                too_big_q, too_big_d;
  logic                seen_q, seen_d;
  logic                stopped_q, stopped_d;
  logic                hex_q, hex_d;
  logic                prefix_q, prefix_d;
  logic [NumNames-1:0] match_q, match_d;
  logic [AddrW-1:0]    echo_idx_q, echo_idx_d;

  logic [7:0]          mem_q [BufferBytes];
  logic [7:0]          rdata_q;
  out_item_t           out_q, out_d;

  logic [7:0]          in_byte;
  logic [4:0]          digit;
  logic [24:0]         code_x10, code_x16, acc;
  logic                named_hit, numeric, truncated;
  logic [15:0]         named_unit, single_unit, high_unit, low_unit;
  logic [20:0]         adj;
  logic [CountW-1:0]   echo_n, last_full;
  logic [AddrW-1:0]    last_idx, rd_addr;
  logic                echo_last;

  assign in_byte  = in_data_i.entity_byte;
  assign digit    = digit_value(in_byte, hex_q);
  assign code_x16 = {code_q, 4'b0000};
  assign code_x10 = {1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0};
  assign acc      = (hex_q ? code_x16 : code_x10) + {21'd0, digit[3:0]};

  always_comb begin
    count_d    = count_q;
    code_d     = code_q;
    too_big_d  = too_big_q;
    seen_d     = seen_q;
    stopped_d  = stopped_q;
    hex_d      = hex_q;
    prefix_d   = prefix_q;
    match_d    = match_q;
    if (cmd_i.clear) begin
      count_d   = '0;
      code_d    = '0;
      too_big_d = 1'b0;
      seen_d    = 1'b0;
      stopped_d = 1'b0;
      hex_d     = 1'b0;
      prefix_d  = 1'b1;
      match_d   = '1;
    end else if (cmd_i.take) begin
      for (int i = 0; i < NumNames; i++) begin
        if (count_q < {4'b0000, NameLen[i]}) begin
          match_d[i] = match_q[i] && (in_byte == NameText[i][count_q[2:0]]);
        end
      end
      if (count_q == 7'd0) begin
        prefix_d = prefix_q && (in_byte == CharAmp);
      end
      if (count_q == 7'd1) begin
        prefix_d = prefix_q && (in_byte == CharHash);
      end
      // The last byte of a reference never takes part in the digit run.
      if (!in_data_i.is_final && count_q >= 7'd2 && !stopped_q) begin
        if (count_q == 7'd2 && (in_byte == CharLowerX || in_byte == CharUpperX)) begin
          hex_d = 1'b1;
        end else if (!digit[4]) begin
          stopped_d = 1'b1;
        end else begin
          seen_d = 1'b1;
          if (!too_big_q) begin
            if (acc > {4'b0000, CodeMax}) begin
              too_big_d = 1'b1;
            end else begin
              code_d = acc[20:0];
            end
          end
        end
      end
      if (count_q != CountMax) begin
        count_d = count_q + 7'd1;
      end
    end
  end

  // Decision on the completed reference.
  always_comb begin
    named_hit  = 1'b0;
    named_unit = '0;
    for (int i = 0; i < NumNames; i++) begin
      if (match_q[i] && count_q == {4'b0000, NameLen[i]}) begin
        named_hit  = 1'b1;
        named_unit = NameUnit[i];
      end
    end
  end

  assign numeric     = (count_q >= 7'd4) && prefix_q && seen_q && !too_big_q;
  assign single_unit = named_hit ? named_unit : code_q[15:0];
  assign adj         = code_q - SurrOffset;
  assign high_unit   = HighSurrBase + {6'd0, adj[19:10]};
  assign low_unit    = LowSurrBase + {6'd0, adj[9:0]};
  assign echo_n      = (count_q < EchoLimitC) ? count_q : EchoLimitC;
  assign last_full   = echo_n - 7'd1;
  assign last_idx    = last_full[AddrW-1:0];
  assign truncated   = count_q > EchoLimitC;
  assign echo_last   = echo_idx_q == last_idx;

  always_comb begin
    if (named_hit || (numeric && code_q != 21'd0 && code_q <= UnitMax)) begin
      status_o.kind = KIND_SINGLE;
    end else if (numeric && code_q > UnitMax) begin
      status_o.kind = KIND_PAIR;
    end else begin
      status_o.kind = KIND_ECHO;
    end
    status_o.echo_last = echo_last;
  end

  assign rd_addr    = cmd_i.rd_start ? '0 : echo_idx_q + AddrW'(1);
  assign echo_idx_d = (cmd_i.rd_start || cmd_i.rd_next) ? rd_addr : echo_idx_q;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_SINGLE: out_d = '{unit_value: single_unit, is_raw_byte: 1'b0,
                            run_end: 1'b1, truncated: 1'b0};
      SEL_HIGH:   out_d = '{unit_value: high_unit, is_raw_byte: 1'b0,
                            run_end: 1'b0, truncated: 1'b0};
      SEL_LOW:    out_d = '{unit_value: low_unit, is_raw_byte: 1'b0,
                            run_end: 1'b1, truncated: 1'b0};
      SEL_RAW:    out_d = '{unit_value: {8'd0, rdata_q}, is_raw_byte: 1'b1,
                            run_end: echo_last, truncated: truncated};
      default:    out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      code_q     <= '0;
      too_big_q  <= 1'b0;
      seen_q     <= 1'b0;
      stopped_q  <= 1'b0;
      hex_q      <= 1'b0;
      prefix_q   <= 1'b1;
      match_q    <= '1;
      echo_idx_q <= '0;
    end else begin
      count_q    <= count_d;
      code_q     <= code_d;
      too_big_q  <= too_big_d;
      seen_q     <= seen_d;
      stopped_q  <= stopped_d;
      hex_q      <= hex_d;
      prefix_q   <= prefix_d;
      match_q    <= match_d;
      echo_idx_q <= echo_idx_d;
    end
  end

  // Buffer memory with a registered read port, and the output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && count_q < BufferBytesC) begin
      mem_q[count_q[AddrW-1:0]] <= in_byte;
    end
    if (cmd_i.rd_start || cmd_i.rd_next) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/hcr_ctrl.sv
// -----------------------------------------------------------------------------
// Character reference decoder controller
// Sequences byte collection, the decision and the transfer of each result.
// -----------------------------------------------------------------------------
module hcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_final_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcr_pkg::dp_cmd_t    cmd_o,
  input  hcr_pkg::dp_status_t status_i
);
  import hcr_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DECIDE,
    ST_SINGLE,
    ST_HIGH,
    ST_LOW,
    ST_ECHO
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, accept;
  dp_cmd_t cmd;

  assign in_stall_o = (state_q != ST_COLLECT);
  assign accept     = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd         = '{take: 1'b0, clear: 1'b0, rd_start: 1'b0, rd_next: 1'b0,
                    load: 1'b0, sel: SEL_SINGLE};
    unique case (state_q)
      ST_COLLECT: begin
        cmd.take = accept;
        if (accept && in_final_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.rd_start = 1'b1;
        unique case (status_i.kind)
          KIND_SINGLE: state_d = ST_SINGLE;
          KIND_PAIR:   state_d = ST_HIGH;
          default:     state_d = ST_ECHO;
        endcase
      end
      ST_SINGLE: begin
        if (out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_SINGLE;
          cmd.clear   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_COLLECT;
        end
      end
      ST_HIGH: begin
        if (out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_HIGH;
          out_valid_d = 1'b1;
          state_d     = ST_LOW;
        end
      end
      ST_LOW: begin
        if (out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_LOW;
          cmd.clear   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_COLLECT;
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_RAW;
          out_valid_d = 1'b1;
          if (status_i.echo_last) begin
            cmd.clear = 1'b1;
            state_d   = ST_COLLECT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> rtl/core/hcr_checker.sv
// -----------------------------------------------------------------------------
// Character reference decoder port checker
// Watches the top-level ports and is bound to every instance of the top level.
// -----------------------------------------------------------------------------
`include "html_char_reference_decoder_top_macros.svh"

module hcr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input hcr_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hcr_pkg::out_item_t out_data_o
);
  import hcr_pkg::*;

  `HCR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed or vanished")

  `HCR_ASSERT_NEXT(a_final_busy, in_valid_i && !in_stall_o && in_data_i.is_final,
    in_stall_o, "input taken straight after the final byte")

  `HCR_ASSERT_SAME(a_decoded_not_cut, out_valid_o && !out_data_o.is_raw_byte,
    !out_data_o.truncated, "decoded unit flagged as truncated")

  `HCR_ASSERT_SAME(a_pair_high_first,
    out_valid_o && !out_data_o.is_raw_byte && !out_data_o.run_end,
    out_data_o.unit_value[15:10] == HighSurrBase[15:10],
    "decoded unit before the end of a run is not a high surrogate")

  `HCR_ASSERT_SAME(a_run_blocks_input,
    out_valid_o && !out_stall_i && !out_data_o.run_end,
    in_stall_o, "input taken while a reference still has results to send")

endmodule

bind html_char_reference_decoder_top hcr_checker u_hcr_checker (.*);

>>> test/html_char_reference_decoder_top_test.sv
// -----------------------------------------------------------------------------
// Character reference decoder testbench
// Streams named, decimal, hex and malformed references through the decoder,
// predicts every UTF-16 unit or echoed byte, and compares the results in order.
// -----------------------------------------------------------------------------
module html_char_reference_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 1000000;
  localparam int LongHold    = 150;
  localparam int DrainCycles = 40;

  // Keeps its own copy of the decoder state and queues the units that each
  // reference should produce; results are matched in order against them.
  class char_ref_board;
    hcr_pkg::out_item_t expected_units[$];
    hcr_pkg::out_item_t received_units[$];
    logic [7:0]  ref_bytes [hcr_pkg::BufferBytes];
    logic [6:0]  byte_total;
    logic [20:0] code_value;
    bit          too_big;
    bit          digit_seen;
    bit          digits_stopped;
    bit          hex_mode;
    string       name_text [6];
    logic [15:0] name_unit [6];
    int          mismatches;
    int          references;
    int          units_seen;
    int          pairs;
    int          echoes;
    int          cut_echoes;

    function new();
      name_text = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;"};
      name_unit = '{16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h00A0};
      clear_state();
    endfunction

    function void clear_state();
      byte_total     = '0;
      code_value     = '0;
      too_big        = 1'b0;
      digit_seen     = 1'b0;
      digits_stopped = 1'b0;
      hex_mode       = 1'b0;
    endfunction

    function int digit_of(logic [7:0] b, bit hex);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (hex && b >= "a" && b <= "f") return int'(b) - 87;
      if (hex && b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
    endfunction

    function void gather_digit(int pos, logic [7:0] b);
      int          d;
      int unsigned grown;
      if (pos < 2 || digits_stopped) return;
      if (pos == 2 && (b == "x" || b == "X")) begin
        hex_mode = 1'b1;
        return;
      end
      d = digit_of(b, hex_mode);
      if (d < 0) begin
        digits_stopped = 1'b1;
        return;
      end
      digit_seen = 1'b1;
      if (!too_big) begin
        grown = int'(code_value) * (hex_mode ? 16 : 10) + d;
        if (grown > 32'h10FFFF) too_big = 1'b1;
        else code_value = grown[20:0];
      end
    endfunction

    function void push_unit(logic [15:0] unit, bit raw, bit last, bit cut);
      hcr_pkg::out_item_t u;
      u.unit_value  = unit;
      u.is_raw_byte = raw;
      u.run_end     = last;
      u.truncated   = cut;
      expected_units.push_back(u);
    endfunction

    // Works out every result of the reference that has just ended.
    function void decode_reference();
      int          limit;
      int          n;
      bit          hit;
      bit          numeric;
      logic [20:0] adj;
      references++;
      for (int i = 0; i < 6; i++) begin
        if (int'(byte_total) == name_text[i].len()) begin
          hit = 1'b1;
          for (int j = 0; j < name_text[i].len(); j++) begin
            if (ref_bytes[j] != name_text[i][j]) hit = 1'b0;
          end
          if (hit) begin
            push_unit(name_unit[i], 1'b0, 1'b1, 1'b0);
            return;
          end
        end
      end
      numeric = byte_total >= 4 && ref_bytes[0] == "&" && ref_bytes[1] == "#" &&
                digit_seen && !too_big;
      if (numeric && code_value >= 1 && code_value <= 21'h00FFFF) begin
        push_unit(code_value[15:0], 1'b0, 1'b1, 1'b0);
      end else if (numeric && code_value > 21'h00FFFF) begin
        adj = code_value - 21'h010000;
        push_unit(16'hD800 + 16'(adj[19:10]), 1'b0, 1'b0, 1'b0);
        push_unit(16'hDC00 + 16'(adj[9:0]), 1'b0, 1'b1, 1'b0);
        pairs++;
      end else begin
        limit = (hcr_pkg::BufferBytes < 32) ? hcr_pkg::BufferBytes : 32;
        n = (int'(byte_total) < limit) ? int'(byte_total) : limit;
        echoes++;
        if (int'(byte_total) > limit) cut_echoes++;
        for (int k = 0; k < n; k++) begin
          push_unit({8'h00, ref_bytes[k]}, 1'b1, k + 1 == n, int'(byte_total) > limit);
        end
      end
    endfunction

    // Results may arrive before the bench has noted the final byte, so both
    // sides are queued and paired off whenever both have something waiting.
    function void pair_off();
      hcr_pkg::out_item_t want;
      hcr_pkg::out_item_t got;
      while (expected_units.size() > 0 && received_units.size() > 0) begin
        want = expected_units.pop_front();
        got  = received_units.pop_front();
        if (got.unit_value !== want.unit_value || got.is_raw_byte !== want.is_raw_byte ||
            got.run_end !== want.run_end || got.truncated !== want.truncated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"Mismatch: expected unit %h raw %b end %b cut %b, ",
                      "got unit %h raw %b end %b cut %b"},
                     want.unit_value, want.is_raw_byte, want.run_end, want.truncated,
                     got.unit_value, got.is_raw_byte, got.run_end, got.truncated);
          end
        end
      end
    endfunction

    function void note_byte(hcr_pkg::in_item_t item);
      int pos;
      pos = int'(byte_total);
      if (pos < hcr_pkg::BufferBytes) ref_bytes[pos] = item.entity_byte;
      if (!item.is_final) gather_digit(pos, item.entity_byte);
      if (byte_total < 7'd127) byte_total++;
      if (item.is_final) begin
        decode_reference();
        clear_state();
      end
      pair_off();
    endfunction

    function void check_unit(hcr_pkg::out_item_t got);
      received_units.push_back(got);
      units_seen++;
      pair_off();
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  hcr_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  hcr_pkg::out_item_t out_data_o;

  char_ref_board board = new();
  logic [7:0]    ref_text[$];
  int            send_idle_pct  = 37;
  int            recv_stall_pct = 72;
  logic          hold_on        = 1'b0;
  int            bytes_sent     = 0;
  int            cycle_count    = 0;

  html_char_reference_decoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check each transfer, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_unit(out_data_o);
    out_stall_i <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic add_byte(input logic [7:0] b);
    ref_text.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) ref_text.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last_byte);
    hcr_pkg::in_item_t item;
    item.entity_byte = b;
    item.is_final    = last_byte;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(item);
    bytes_sent++;
  endtask

  task automatic send_reference();
    for (int i = 0; i < ref_text.size(); i++) send_byte(ref_text[i], i == ref_text.size() - 1);
    ref_text.delete();
  endtask

  // Mostly well-formed references with random content; the rest is noise,
  // short forms and broken names.
  task automatic make_random_reference();
    int          kind;
    int          pick;
    int unsigned value;
    bit          hex;
    bit          huge;
    string       digits;
    logic [7:0]  ch;
    string       hex_chars = "0123456789abcdefABCDEF";
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        add_text(board.name_text[$urandom_range(5)]);
        pick = $urandom_range(5);
        if (pick == 0) ref_text[$urandom_range(ref_text.size() - 1)] = 8'($urandom_range(255));
        else if (pick == 1) ref_text.delete(ref_text.size() - 1);
      end
      2, 3, 4, 5: begin
        hex  = kind >= 4;
        huge = 1'b0;
        add_text("&#");
        if (hex) add_byte($urandom_range(1) ? "x" : "X");
        case ($urandom_range(7))
          0: value = 0;
          1: value = $urandom_range(32'hFFFF, 1);
          2: value = $urandom_range(32'hDFFF, 32'hD800);
          3: value = $urandom_range(32'h10FFFF, 32'h10000);
          4: value = $urandom_range(32'h1FFFFF, 32'h110000);
          5: begin
            case ($urandom_range(4))
              0: value = 1;
              1: value = 32'hFFFF;
              2: value = 32'h10000;
              3: value = 32'h10FFFF;
              default: value = 32'h110000;
            endcase
          end
          6: value = $urandom_range(127, 1);
          default: begin
            value = $urandom_range(32'hFFFF, 1);
            huge  = 1'b1;
          end
        endcase
        repeat ($urandom_range(2)) add_byte("0");
        digits = hex ? $sformatf("%0h", value) : $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
          ch = digits[i];
          if (ch >= "a" && $urandom_range(1)) ch = ch - 8'd32;
          add_byte(ch);
        end
        if (huge) begin
          repeat ($urandom_range(10, 6)) begin
            add_byte(hex ? hex_chars[$urandom_range(21)] : 8'($urandom_range(57, 48)));
          end
        end
        // A non-digit ends the digit run; whatever follows is ignored.
        if ($urandom_range(4) == 0) begin
          add_byte("g");
          repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
        end
        add_byte(($urandom_range(6) == 0) ? 8'($urandom_range(255)) : ";");
      end
      6: begin
        add_text("&#");
        if ($urandom_range(1)) add_byte("x");
        repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
        add_byte(";");
      end
      7: repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255)));
      8: begin
        add_byte("&");
        repeat ($urandom_range(40, 32)) add_byte(8'($urandom_range(255)));
      end
      default: begin
        add_text("&#");
        if ($urandom_range(1)) add_byte(8'($urandom_range(57, 48)));
        add_byte(";");
      end
    endcase
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_random_reference();
      send_reference();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lone extreme bytes, a name, the largest pair, zero and an empty number.
    add_byte(8'hFF);
    send_reference();
    add_byte(8'h00);
    send_reference();
    add_text("&lt;");
    send_reference();
    add_text("&#x10FFFF;");
    send_reference();
    add_text("&#0;");
    send_reference();
    add_text("&#;");
    send_reference();

    run_random(100);

    send_idle_pct  = 72;
    recv_stall_pct = 37;
    run_random(100);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    run_random(40);

    // Longer than the byte counter can hold; the digits still count.
    add_text("&#");
    repeat (124) add_byte("0");
    add_text("97;");
    send_reference();

    in_valid_i <= 1'b0;
    while (board.expected_units.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.received_units.size() > 0) begin
      $display("%0d results arrived with no transfer to account for them.",
               board.received_units.size());
    end
    $display("Sent %0d references in %0d bytes and checked %0d results, %0d mismatches.",
             board.references, bytes_sent, board.units_seen, board.mismatches);
    $display("Covered %0d surrogate pairs and %0d raw echoes, %0d of them cut short.",
             board.pairs, board.echoes, board.cut_echoes);
    if (board.mismatches == 0 && board.received_units.size() == 0 &&
        board.expected_units.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
